// ===== sv/lfd_pkg.sv =====
// shared types, constants and helpers of the length-prefixed deframer
package lfd_pkg;

    // width of the length and offset counters (8 to 32)
    localparam int LENGTH_BITS = 32;

    // largest length the counters can hold
    localparam logic [31:0] LEN_MAX = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    // header byte positions
    localparam logic [2:0] HDR_FIRST         = 3'd0;
    localparam logic [2:0] HDR_CONTENT_FIRST = 3'd4;
    localparam logic [2:0] HDR_LAST          = 3'd7;

    // phase of the frame; the code doubles as the section tag of a byte
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_NAME    = 2'd1,
        PH_CONTENT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  section;
        logic [31:0] offset;
        logic        section_last;
        logic        frame_done;
        logic [31:0] name_length;
        logic [31:0] content_length;
    } result_t;

    // saturate a decoded length to the counter range
    function automatic logic [31:0] clamp_len(input logic [31:0] v);
        clamp_len = (v > LEN_MAX) ? LEN_MAX : v;
    endfunction

endpackage

// ===== sv/lfd_if.sv =====
// stream channels of the deframer: raw byte input and tagged byte output
interface lfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface lfd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [1:0]  section;
    logic [31:0] offset;
    logic        section_last;
    logic        frame_done;
    logic [31:0] name_length;
    logic [31:0] content_length;

    modport source (output valid, output byte_out, output section, output offset,
                    output section_last, output frame_done, output name_length,
                    output content_length, input ready);
    modport sink   (input valid, input byte_out, input section, input offset,
                    input section_last, input frame_done, input name_length,
                    input content_length, output ready);
endinterface

// ===== sv/lfd_tracker.sv =====
// frame position tracker: header assembly, section counters and byte tagging
module lfd_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       byte_in,
    output lfd_pkg::result_t result
);

    lfd_pkg::phase_t                  phase_reg, phase_next;
    logic [2:0]                       hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]                      name_len_reg, name_len_next;
    logic [31:0]                      content_len_reg, content_len_next;
    logic [lfd_pkg::LENGTH_BITS-1:0]  sec_off_reg, sec_off_next;

    logic [31:0] len;
    logic [31:0] name_asm;
    logic [31:0] content_asm;
    logic [31:0] name_sat;
    logic [31:0] content_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= lfd_pkg::PH_HEADER;
            hdr_cnt_reg     <= lfd_pkg::HDR_FIRST;
            name_len_reg    <= '0;
            content_len_reg <= '0;
            sec_off_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg       <= phase_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            name_len_reg    <= name_len_next;
            content_len_reg <= content_len_next;
            sec_off_reg     <= sec_off_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        name_len_next    = name_len_reg;
        content_len_next = content_len_reg;
        sec_off_next     = sec_off_reg;

        len         = (phase_reg == lfd_pkg::PH_NAME) ? name_len_reg : content_len_reg;
        name_asm    = (hdr_cnt_reg == lfd_pkg::HDR_FIRST) ? {24'd0, byte_in}
                                                          : {name_len_reg[23:0], byte_in};
        content_asm = (hdr_cnt_reg == lfd_pkg::HDR_CONTENT_FIRST)
                      ? {24'd0, byte_in} : {content_len_reg[23:0], byte_in};
        name_sat    = lfd_pkg::clamp_len(name_len_reg);
        content_sat = lfd_pkg::clamp_len(content_asm);

        result                = '0;
        result.byte_out       = byte_in;
        result.section        = 2'(lfd_pkg::PH_HEADER);

        case (phase_reg)
            lfd_pkg::PH_NAME, lfd_pkg::PH_CONTENT:
            begin
                result.section        = 2'(phase_reg);
                result.offset         = 32'(sec_off_reg);
                result.name_length    = name_len_reg;
                result.content_length = content_len_reg;
                if (len == 32'd0 || 32'(sec_off_reg) >= len - 32'd1)
                begin
                    result.section_last = 1'b1;
                    sec_off_next        = '0;
                    if (phase_reg == lfd_pkg::PH_NAME && content_len_reg != 32'd0)
                    begin
                        phase_next = lfd_pkg::PH_CONTENT;
                    end
                    else
                    begin
                        phase_next        = lfd_pkg::PH_HEADER;
                        result.frame_done = 1'b1;
                    end
                end
                else
                begin
                    sec_off_next = sec_off_reg + {{(lfd_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                // header byte; an unused phase code behaves the same
                result.offset = 32'(hdr_cnt_reg);
                if (hdr_cnt_reg < lfd_pkg::HDR_CONTENT_FIRST)
                begin
                    name_len_next = name_asm;
                end
                else
                begin
                    content_len_next = content_asm;
                end
                if (hdr_cnt_reg == lfd_pkg::HDR_LAST)
                begin
                    // empty sections resolved here, on the last header byte
                    result.section_last   = 1'b1;
                    result.name_length    = name_sat;
                    result.content_length = content_sat;
                    name_len_next         = name_sat;
                    content_len_next      = content_sat;
                    hdr_cnt_next          = lfd_pkg::HDR_FIRST;
                    sec_off_next          = '0;
                    if (name_sat != 32'd0)
                    begin
                        phase_next = lfd_pkg::PH_NAME;
                    end
                    else if (content_sat != 32'd0)
                    begin
                        phase_next = lfd_pkg::PH_CONTENT;
                    end
                    else
                    begin
                        phase_next        = lfd_pkg::PH_HEADER;
                        result.frame_done = 1'b1;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    phase_next   = lfd_pkg::PH_HEADER;
                end
            end
        endcase
    end

endmodule

// ===== sv/length_prefixed_file_deframer_unit.sv =====
// top level of the length-prefixed frame deframer
//
//  channel | dir | payload                                         | role
//  --------+-----+-------------------------------------------------+---------------------------
//  rx      | in  | byte_in                                         | raw stream, one byte each
//  tx      | out | byte_out, section, offset, section_last,        | tagged byte, one per input
//          |     | frame_done, name_length, content_length         |
//
// one byte per clock while tx drains: a transaction on rx produces its result in the output register
// on the same edge, so throughput is one byte per cycle unless a stall on tx fills the register
// rx.ready is high while the output register is empty or being drained by tx.ready
// a stall on tx holds the result and blocks rx only when the register is full
// reset clears the frame state to the start of a header and empties the output register
module length_prefixed_file_deframer_unit (
    input  logic       clk,
    input  logic       rst_n,
    lfd_in_if.sink     rx,
    lfd_out_if.source  tx
);

    logic              take;
    lfd_pkg::result_t  result;
    lfd_pkg::result_t  result_reg;
    logic              tx_valid_reg;

    assign rx.ready = !tx_valid_reg || tx.ready;
    assign take     = rx.valid && rx.ready;

    lfd_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .byte_in (rx.byte_in),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            tx_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign tx.valid          = tx_valid_reg;
    assign tx.byte_out       = result_reg.byte_out;
    assign tx.section        = result_reg.section;
    assign tx.offset         = result_reg.offset;
    assign tx.section_last   = result_reg.section_last;
    assign tx.frame_done     = result_reg.frame_done;
    assign tx.name_length    = result_reg.name_length;
    assign tx.content_length = result_reg.content_length;

endmodule

// ===== tb/lfd_deframe_checker.sv =====
// checker for the deframer: follows the frame state, predicts each tagged byte and compares
module lfd_deframe_checker (
    input  logic clk,
    input  logic rst_n,
    lfd_in_if    rx_mon,
    lfd_out_if   tx_mon,
    output int   fail_count,
    output int   pending
);

    lfd_pkg::phase_t frame_phase;
    logic [2:0]      hdr_idx;
    logic [31:0]     name_len;
    logic [31:0]     content_len;
    logic [31:0]     sec_pos;

    lfd_pkg::result_t expected_tags[$];
    int               mismatches = 0;
    int               waiting    = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, seen);
            mismatches++;
        end
    endtask

    // advance the frame state by one byte and work out its tag
    task automatic tag_next_byte(input logic [7:0] b, output lfd_pkg::result_t r);
        logic [31:0] span;
        r          = '0;
        r.byte_out = b;
        if (frame_phase == lfd_pkg::PH_NAME || frame_phase == lfd_pkg::PH_CONTENT)
        begin
            span             = (frame_phase == lfd_pkg::PH_NAME) ? name_len : content_len;
            r.section        = frame_phase;
            r.offset         = sec_pos;
            r.name_length    = name_len;
            r.content_length = content_len;
            if (span == 32'd0 || sec_pos >= span - 32'd1)
            begin
                r.section_last = 1'b1;
                sec_pos        = '0;
                if (frame_phase == lfd_pkg::PH_NAME && content_len != 32'd0)
                    frame_phase = lfd_pkg::PH_CONTENT;
                else
                begin
                    frame_phase  = lfd_pkg::PH_HEADER;
                    r.frame_done = 1'b1;
                end
            end
            else
                sec_pos = sec_pos + 32'd1;
        end
        else
        begin
            r.section = lfd_pkg::PH_HEADER;
            r.offset  = {29'd0, hdr_idx};
            // lengths arrive most significant byte first
            if (hdr_idx < lfd_pkg::HDR_CONTENT_FIRST)
                name_len = (hdr_idx == lfd_pkg::HDR_FIRST) ? {24'd0, b} : {name_len[23:0], b};
            else
                content_len = (hdr_idx == lfd_pkg::HDR_CONTENT_FIRST)
                              ? {24'd0, b} : {content_len[23:0], b};
            if (hdr_idx == lfd_pkg::HDR_LAST)
            begin
                if (name_len > lfd_pkg::LEN_MAX)
                    name_len = lfd_pkg::LEN_MAX;
                if (content_len > lfd_pkg::LEN_MAX)
                    content_len = lfd_pkg::LEN_MAX;
                r.section_last   = 1'b1;
                r.name_length    = name_len;
                r.content_length = content_len;
                hdr_idx          = '0;
                sec_pos          = '0;
                // empty sections are skipped straight from the last header byte
                if (name_len != 32'd0)
                    frame_phase = lfd_pkg::PH_NAME;
                else if (content_len != 32'd0)
                    frame_phase = lfd_pkg::PH_CONTENT;
                else
                begin
                    frame_phase  = lfd_pkg::PH_HEADER;
                    r.frame_done = 1'b1;
                end
            end
            else
                hdr_idx = hdr_idx + 3'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lfd_pkg::result_t want;
        if (!rst_n)
        begin
            frame_phase = lfd_pkg::PH_HEADER;
            hdr_idx     = '0;
            name_len    = '0;
            content_len = '0;
            sec_pos     = '0;
            expected_tags.delete();
            waiting = 0;
        end
        else
        begin
            // retire the output transaction first so a new input never matches it
            if (tx_mon.valid && tx_mon.ready)
            begin
                if (expected_tags.size() == 0)
                begin
                    $error("output transaction with no byte outstanding: byte_out 0x%0h",
                           tx_mon.byte_out);
                    mismatches++;
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("byte_out", 32'(want.byte_out), 32'(tx_mon.byte_out));
                    check_field("section", 32'(want.section), 32'(tx_mon.section));
                    check_field("offset", want.offset, tx_mon.offset);
                    check_field("section_last", 32'(want.section_last),
                                32'(tx_mon.section_last));
                    check_field("frame_done", 32'(want.frame_done),
                                32'(tx_mon.frame_done));
                    check_field("name_length", want.name_length, tx_mon.name_length);
                    check_field("content_length", want.content_length,
                                tx_mon.content_length);
                end
            end
            if (rx_mon.valid && rx_mon.ready)
            begin
                tag_next_byte(rx_mon.byte_in, want);
                expected_tags.push_back(want);
            end
            waiting = expected_tags.size();
        end
    end

endmodule

// ===== tb/tb_length_prefixed_file_deframer_unit.sv =====
// testbench top of the deframer: byte stream stimulus, output back-pressure and verdict
module tb_length_prefixed_file_deframer_unit;

    logic clk;
    logic rst_n;

    lfd_in_if  rx ();
    lfd_out_if tx ();

    int fail_count;
    int pending;
    int bytes_sent = 0;
    bit gaps_on    = 1'b1;

    length_prefixed_file_deframer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx)
    );

    lfd_deframe_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_mon     (rx),
        .tx_mon     (tx),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // output side: random stalls in stretches, plus one long hold-off
    initial
    begin : drain_side
        int cyc;
        int hold;
        int mode;
        cyc     = 0;
        hold    = 0;
        mode    = 0;
        tx.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 200 == 0)
                mode = $urandom_range(0, 2);
            if (cyc == 400)
                hold = 150;
            if (hold > 0)
            begin
                hold--;
                tx.ready <= 1'b0;
            end
            else if (mode == 0)
                tx.ready <= 1'b1;
            else if (mode == 1)
                tx.ready <= ($urandom_range(0, 3) != 0);
            else if ($urandom_range(0, 39) == 0)
            begin
                hold = $urandom_range(8, 30);
                tx.ready <= 1'b0;
            end
            else
                tx.ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.byte_in <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        bytes_sent++;
    endtask

    task automatic push_header(input logic [31:0] nl, input logic [31:0] cl);
        for (int i = 3; i >= 0; i--)
            push_byte(nl[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            push_byte(cl[8*i +: 8]);
    endtask

    task automatic push_frame(input logic [31:0] nl, input logic [31:0] cl);
        push_header(nl, cl);
        repeat (nl) push_byte(8'($urandom));
        repeat (cl) push_byte(8'($urandom));
    endtask

    // hold the input off until every outstanding byte has come out
    task automatic wait_drained();
        rx.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 32'd0;
        else if (r < 80)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(7, 30);
        else
            return $urandom_range(31, 120);
    endfunction

    initial
    begin : feed_side
        bit paused_mid;
        paused_mid = 1'b0;
        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.byte_in = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty frame, then a lone name byte, then a lone content byte
        gaps_on = 1'b0;
        push_header(32'd0, 32'd0);
        push_header(32'd1, 32'd0);
        push_byte(8'hFF);
        push_header(32'd0, 32'd1);
        push_byte(8'h00);
        wait_drained();

        while (bytes_sent < 740)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            push_frame(pick_len(), pick_len());
            if (!paused_mid && bytes_sent > 450)
            begin
                paused_mid = 1'b1;
                wait_drained();
            end
        end

        // oversize lengths: the name section never ends within the run
        gaps_on = 1'b1;
        push_header(32'hFFFF_FFFF, 32'h8000_0001);
        repeat (6) push_byte(8'($urandom));

        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lfd_pkg.sv
sv/lfd_if.sv
sv/lfd_tracker.sv
sv/length_prefixed_file_deframer_unit.sv
tb/lfd_deframe_checker.sv
tb/tb_length_prefixed_file_deframer_unit.sv
